>>> src/nfc_pkg.sv
package nfc_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned ExpWidth  = 13;
  localparam int unsigned PipeDepth = 4;

  typedef enum logic [2:0] {
    T_I8  = 3'd0,
    T_I16 = 3'd1,
    T_I32 = 3'd2,
    T_I64 = 3'd3,
    T_F32 = 3'd4,
    T_F64 = 3'd5
  } type_e;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_BSWAP   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DIRECT   = 2'd0,
    KIND_TO_INT   = 2'd1,
    KIND_TO_FLOAT = 2'd2
  } kind_e;

  typedef logic signed [ExpWidth-1:0] exp_t;

  // operand as sign, magnitude and binary exponent of bit 0 (or of the top bit after normalize)
  typedef struct packed {
    kind_e                kind;
    logic                 neg;
    logic                 huge;
    logic                 dst_dbl;
    logic [1:0]           dst_w;
    logic [DataWidth-1:0] mant;
    exp_t                 exp;
    logic [DataWidth-1:0] direct;
  } op_t;

  typedef struct packed {
    kind_e                kind;
    logic                 neg;
    logic                 huge;
    logic                 dst_dbl;
    logic [1:0]           dst_w;
    logic [DataWidth-1:0] q;
    logic                 guard;
    logic                 sticky;
    logic [11:0]          eadj;
    logic [DataWidth-1:0] direct;
  } aligned_t;

  function automatic logic [DataWidth-1:0] type_mask(logic [2:0] code);
    logic [DataWidth-1:0] m;
    case (code)
      T_I8:          m = 64'h0000_0000_0000_00FF;
      T_I16:         m = 64'h0000_0000_0000_FFFF;
      T_I32, T_F32:  m = 64'h0000_0000_FFFF_FFFF;
      T_I64, T_F64:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:       m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> src/nfc_unpack.sv
module nfc_unpack
  import nfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        opcode_i,
  input  logic [2:0]  src_type_i,
  input  logic [2:0]  dst_type_i,
  input  logic [63:0] source_value_i,
  output logic        valid_o,
  output op_t         op_o
);

  logic        valid_q;
  op_t         op_d, op_q;
  logic [63:0] v, sx, imag, frac, bswap;
  logic [10:0] ef;
  logic        fneg, special, src_ok, dst_ok, src_int, dst_int, dst_dbl;
  type_e       st, dt;

  assign st = type_e'(src_type_i);
  assign dt = type_e'(dst_type_i);
  assign src_ok  = (src_type_i inside {[T_I8:T_F64]});
  assign dst_ok  = (dst_type_i inside {[T_I8:T_F64]});
  assign src_int = (src_type_i inside {[T_I8:T_I64]});
  assign dst_int = (dst_type_i inside {[T_I8:T_I64]});
  assign dst_dbl = (dt == T_F64);
  assign v = source_value_i & type_mask(src_type_i);

  always_comb begin
    case (st)
      T_I8:    sx = {{56{v[7]}}, v[7:0]};
      T_I16:   sx = {{48{v[15]}}, v[15:0]};
      T_I32:   sx = {{32{v[31]}}, v[31:0]};
      default: sx = v;
    endcase
    imag = sx[63] ? (~sx + 64'd1) : sx;
    case (st)
      T_I16:        bswap = {48'b0, v[7:0], v[15:8]};
      T_I32, T_F32: bswap = {32'b0, v[7:0], v[15:8], v[23:16], v[31:24]};
      T_I64, T_F64: bswap = {v[7:0], v[15:8], v[23:16], v[31:24],
                             v[39:32], v[47:40], v[55:48], v[63:56]};
      default:      bswap = v;
    endcase
    if (st == T_F64) begin
      fneg    = v[63];
      ef      = v[62:52];
      frac    = {12'b0, v[51:0]};
      special = (ef == 11'h7FF);
    end else begin
      fneg    = v[31];
      ef      = {3'b0, v[30:23]};
      frac    = {41'b0, v[22:0]};
      special = (ef == 11'h0FF);
    end
  end

  always_comb begin
    op_d         = '0;
    op_d.kind    = KIND_DIRECT;
    op_d.dst_dbl = dst_dbl;
    op_d.dst_w   = dst_type_i[1:0];
    op_d.direct  = '0;
    if (!src_ok) begin
      op_d.direct = '0;
    end else if (opcode_i == OP_BSWAP) begin
      op_d.direct = bswap;
    end else if (!dst_ok) begin
      op_d.direct = '0;
    end else if (src_int) begin
      op_d.neg  = sx[63];
      op_d.mant = imag;
      op_d.exp  = '0;
      if (dst_int) begin
        op_d.direct = sx & type_mask(dst_type_i);
      end else if (imag == '0) begin
        op_d.direct = '0;
      end else begin
        op_d.kind = KIND_TO_FLOAT;
      end
    end else begin
      op_d.neg = fneg;
      if (ef == '0) begin
        op_d.mant = frac;
        op_d.exp  = (st == T_F64) ? -13'sd1074 : -13'sd149;
      end else begin
        op_d.mant = (st == T_F64) ? (frac | (64'd1 << 52)) : (frac | (64'd1 << 23));
        op_d.exp  = $signed({2'b00, ef}) - ((st == T_F64) ? 13'sd1075 : 13'sd150);
      end
      op_d.huge = special;
      if (dst_int) begin
        // NaN and zero give zero; infinity saturates later
        if ((special && frac != '0) || (!special && op_d.mant == '0)) begin
          op_d.direct = '0;
        end else begin
          op_d.kind = KIND_TO_INT;
        end
      end else if (dt == st) begin
        op_d.direct = v;
      end else if (dst_dbl) begin
        if (special) begin
          op_d.direct = {fneg, 11'h7FF, 52'b0} |
                        ((frac != '0) ? ((64'd1 << 51) | (frac << 29)) : 64'd0);
        end else if (op_d.mant == '0) begin
          op_d.direct = {fneg, 63'b0};
        end else begin
          op_d.kind = KIND_TO_FLOAT;
        end
      end else begin
        if (special) begin
          op_d.direct = {32'b0, fneg, 8'hFF, 23'b0} |
                        ((frac != '0) ? (64'h0040_0000 | (frac >> 29)) : 64'd0);
        end else if (op_d.mant == '0) begin
          op_d.direct = {32'b0, fneg, 31'b0};
        end else begin
          op_d.kind = KIND_TO_FLOAT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

>>> src/nfc_normalize.sv
module nfc_normalize
  import nfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  op_t  op_i,
  output logic valid_o,
  output op_t  op_o
);

  logic       valid_q;
  op_t        op_d, op_q;
  logic [5:0] top;

  // find the leading one
  always_comb begin
    top = '0;
    for (int i = 0; i < DataWidth; i++) begin
      if (op_i.mant[i]) top = 6'(i);
    end
  end

  always_comb begin
    op_d      = op_i;
    op_d.mant = op_i.mant << (6'd63 - top);
    op_d.exp  = op_i.exp + $signed({7'b0, top});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

>>> src/nfc_align.sv
module nfc_align
  import nfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  op_t      op_i,
  output logic     valid_o,
  output aligned_t al_o
);

  logic               valid_q;
  aligned_t           al_d, al_q;
  exp_t               biased;
  logic signed [13:0] keep, sft;
  logic [6:0]         amt;
  logic [127:0]       sh;

  always_comb begin
    biased = op_i.exp + (op_i.dst_dbl ? 13'sd1023 : 13'sd127);
    keep   = '0;
    al_d          = '0;
    al_d.kind     = op_i.kind;
    al_d.neg      = op_i.neg;
    al_d.huge     = op_i.huge;
    al_d.dst_dbl  = op_i.dst_dbl;
    al_d.dst_w    = op_i.dst_w;
    al_d.direct   = op_i.direct;
    if (op_i.kind == KIND_TO_INT) begin
      // truncate: shift the integer part down to bit 0
      if (op_i.exp >= 13'sd64) al_d.huge = 1'b1;
      sft = (op_i.exp < 0) ? 14'sd127 : (14'sd63 - 14'(op_i.exp));
    end else begin
      // keep p bits when normal, fewer when subnormal
      if (biased > 0) begin
        keep      = op_i.dst_dbl ? 14'sd53 : 14'sd24;
        al_d.eadj = 12'(biased - 13'sd1);
      end else begin
        keep = (op_i.dst_dbl ? 14'sd52 : 14'sd23) + 14'(biased);
      end
      sft = 14'sd64 - keep;
    end
    amt = (sft > 14'sd127) ? 7'd127 : (sft < 0) ? 7'd0 : sft[6:0];
    sh  = {op_i.mant, 64'b0} >> amt;
    al_d.q      = sh[127:64];
    al_d.guard  = sh[63];
    al_d.sticky = |sh[62:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    al_q <= al_d;
  end

  assign valid_o = valid_q;
  assign al_o    = al_q;

endmodule

>>> src/nfc_pack.sv
module nfc_pack
  import nfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  aligned_t    al_i,
  output logic        valid_o,
  output logic [63:0] result_o
);

  logic        valid_q;
  logic [63:0] res_d, res_q;
  logic [63:0] lim, mask, mag, qr, packed_v, emax_sh, sbit;
  logic        rnd;

  always_comb begin
    case (al_i.dst_w)
      2'd0:    begin lim = 64'd1 << 7;  mask = 64'hFF;        end
      2'd1:    begin lim = 64'd1 << 15; mask = 64'hFFFF;      end
      2'd2:    begin lim = 64'd1 << 31; mask = 64'hFFFF_FFFF; end
      default: begin lim = 64'd1 << 63; mask = '1;            end
    endcase
    // saturate, then apply the sign
    if (al_i.neg) begin
      mag = (al_i.huge || al_i.q > lim) ? lim : al_i.q;
      mag = (~mag + 64'd1) & mask;
    end else begin
      mag = (al_i.huge || al_i.q > lim - 64'd1) ? (lim - 64'd1) : al_i.q;
      mag = mag & mask;
    end
    // round to nearest even; a carry out of the fraction bumps the exponent
    rnd      = al_i.guard & (al_i.sticky | al_i.q[0]);
    qr       = al_i.q + {63'b0, rnd};
    packed_v = ({52'b0, al_i.eadj} << (al_i.dst_dbl ? 52 : 23)) + qr;
    emax_sh  = al_i.dst_dbl ? (64'h7FF << 52) : (64'hFF << 23);
    sbit     = {63'b0, al_i.neg} << (al_i.dst_dbl ? 63 : 31);
    case (al_i.kind)
      KIND_TO_INT:   res_d = mag;
      KIND_TO_FLOAT: res_d = sbit | ((packed_v >= emax_sh) ? emax_sh : packed_v);
      default:       res_d = al_i.direct;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> src/numeric_format_converter_unit.sv
// Numeric format converter: signed 8/16/32/64-bit integers, IEEE single and
// IEEE double, plus a byte reverse at the source width.
//
// Command channel: drive opcode_i, src_type_i, dst_type_i and source_value_i
// with start_i high; the transaction is taken at the rising edge where start_i
// is high and busy is low. busy is tied low: the unit takes a transaction
// every cycle.
// Result channel: result_value_o is shown for exactly one cycle with
// result_valid_o high, after the unpack, normalize, align and pack registers,
// in issue order.
// The receiver cannot stall; no result is held or dropped.
// Throughput is one transaction per cycle; the pipe has four register stages:
// unpack, normalize (leading-one search and left shift), align (the rounding
// or truncation right shift), pack (round increment, saturation, exponent
// overflow to infinity).
// Reset (rst_ni low, asynchronous) clears the stage valid bits, so any
// transaction in flight is dropped and no strobe follows it.
module numeric_format_converter_unit
  import nfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [2:0]  src_type_i,
  input  logic [2:0]  dst_type_i,
  input  logic [63:0] source_value_i,
  output logic        result_valid_o,
  output logic [63:0] result_value_o
);

  logic     accept;
  logic     v1, v2, v3;
  op_t      op1, op2;
  aligned_t al3;

  // never stalls: each stage advances every cycle
  assign busy   = 1'b0;
  assign accept = start_i & ~busy;

  // split the operand into sign, magnitude and exponent; settle trivial cases
  nfc_unpack u_unpack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .opcode_i       (opcode_i),
    .src_type_i     (src_type_i),
    .dst_type_i     (dst_type_i),
    .source_value_i (source_value_i),
    .valid_o        (v1),
    .op_o           (op1)
  );

  // move the leading one to bit 63
  nfc_normalize u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .op_i    (op1),
    .valid_o (v2),
    .op_o    (op2)
  );

  // shift into place for the destination; collect guard and sticky
  nfc_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .op_i    (op2),
    .valid_o (v3),
    .al_o    (al3)
  );

  // round or saturate, drive the result register
  nfc_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v3),
    .al_i     (al3),
    .valid_o  (result_valid_o),
    .result_o (result_value_o)
  );

endmodule

>>> src/nfc_checker.sv
module nfc_checker
  import nfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy,
  input logic        opcode_i,
  input logic [2:0]  src_type_i,
  input logic [2:0]  dst_type_i,
  input logic [63:0] source_value_i,
  input logic        result_valid_o,
  input logic [63:0] result_value_o
);

  logic [3:0] rst_hist_q;
  logic       settled;

  // count edges since reset release; settled once the pipe has filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_hist_q <= '0;
    end else begin
      rst_hist_q <= {rst_hist_q[2:0], 1'b1};
    end
  end

  assign settled = &rst_hist_q;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  a_one_result_each: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled |-> (result_valid_o == $past(start_i && !busy, 4)))
    else $error("result strobe does not match issued transactions");

  a_bad_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled && $past(start_i && (src_type_i == 3'd6 || src_type_i == 3'd7), 4))
    |-> (result_value_o == '0)) else $error("unused source type gave nonzero");

  a_f32_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled && $past(start_i && opcode_i == OP_CONVERT && dst_type_i == T_F32, 4))
    |-> (result_value_o[63:32] == '0)) else $error("single result has upper bits");

endmodule

bind numeric_format_converter_unit nfc_checker u_nfc_checker (.*);

>>> sim/numeric_format_converter_unit_test.sv
`timescale 1ns / 100ps

module numeric_format_converter_unit_test;
  import nfc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = PipeDepth + 4;
  localparam int unsigned RandomItems = 850;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy;
  logic        opcode_i;
  logic [2:0]  src_type_i;
  logic [2:0]  dst_type_i;
  logic [63:0] source_value_i;
  logic        result_valid_o;
  logic [63:0] result_value_o;

  numeric_format_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .src_type_i     (src_type_i),
    .dst_type_i     (dst_type_i),
    .source_value_i (source_value_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o)
  );

  // Conversion predictor and the queue of converted values still owed.
  class conversion_board;
    logic [63:0] owed_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] width_mask(int w);
      return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    static function int type_bits(logic [2:0] code);
      case (code)
        T_I8:         return 8;
        T_I16:        return 16;
        T_I32, T_F32: return 32;
        T_I64, T_F64: return 64;
        default:      return 0;
      endcase
    endfunction

    static function int msb_index(logic [63:0] m);
      int n;
      n = 0;
      while (n < 63 && (m >> (n + 1)) != 0) n++;
      return n;
    endfunction

    // Round (-1)^neg * m * 2^e to nearest even in single or double.
    static function logic [63:0] round_to_float(bit neg, logic [63:0] m, int e, bit dbl);
      int prec, bias, emax, shift, sub_shift, biased;
      logic [63:0] sbit, q, rem, half;
      prec = dbl ? 53 : 24;
      bias = dbl ? 1023 : 127;
      emax = dbl ? 2047 : 255;
      sbit = neg ? (64'd1 << (dbl ? 63 : 31)) : 64'd0;
      if (m == 0) return sbit;
      shift = msb_index(m) - (prec - 1);
      sub_shift = (1 - bias - (prec - 1)) - e;
      if (sub_shift > shift) shift = sub_shift;
      if (shift <= 0) begin
        q = m << (-shift);
      end else begin
        if (shift >= 65) begin
          q = 0; rem = 0; half = 1;
        end else if (shift == 64) begin
          q = 0; rem = m; half = 64'd1 << 63;
        end else begin
          q = m >> shift;
          rem = m & width_mask(shift);
          half = 64'd1 << (shift - 1);
        end
        if (rem > half || (rem == half && q[0])) q++;
      end
      // carry out of the round increment: renormalize
      if ((q >> prec) != 0) begin
        q = q >> 1;
        shift++;
      end
      if ((q >> (prec - 1)) != 0) begin
        biased = e + shift + (prec - 1) + bias;
        if (biased >= emax) return sbit | (64'(emax) << (prec - 1));
        return sbit | (64'(biased) << (prec - 1)) | (q & width_mask(prec - 1));
      end
      return sbit | q;
    endfunction

    // Truncate toward zero, clamp to the signed range, NaN yields zero.
    static function logic [63:0] float_to_int(bit neg, logic [63:0] m, int e,
                                              bit inf, bit nan, int w);
      logic [63:0] lim, mag;
      bit huge;
      lim = 64'd1 << (w - 1);
      mag = 0;
      huge = inf;
      if (nan) return 0;
      if (!huge && m != 0) begin
        if (e >= 0) begin
          if (msb_index(m) + e >= 64) huge = 1;
          else mag = m << e;
        end else if (-e < 64) begin
          mag = m >> (-e);
        end
      end
      if (neg) begin
        if (huge || mag > lim) mag = lim;
        return (64'd0 - mag) & width_mask(w);
      end
      if (huge || mag > lim - 64'd1) mag = lim - 64'd1;
      return mag & width_mask(w);
    endfunction

    static function logic [63:0] convert(op_e op, logic [2:0] st, logic [2:0] dt,
                                         logic [63:0] raw);
      int sw, nb, e;
      logic [63:0] v, r, s, mag, fr, m, ef, efmax;
      bit neg, dbl, nan, inf;
      sw = type_bits(st);
      r = 0;
      if (sw == 0) return 0;
      v = raw & width_mask(sw);
      if (op == OP_BSWAP) begin
        nb = sw / 8;
        for (int i = 0; i < nb; i++) r |= ((v >> (8 * i)) & 64'hFF) << (8 * (nb - 1 - i));
        return r;
      end
      if (dt > T_F64) return 0;
      if (st <= T_I64) begin
        s = (sw < 64 && v[sw-1]) ? (v | ~width_mask(sw)) : v;
        if (dt <= T_I64) begin
          r = s;
        end else begin
          neg = s[63];
          mag = neg ? (64'd0 - s) : s;
          r = round_to_float(neg, mag, 0, dt == T_F64);
        end
      end else begin
        dbl = (st == T_F64);
        neg = dbl ? v[63] : v[31];
        ef = dbl ? ((v >> 52) & 64'h7FF) : ((v >> 23) & 64'hFF);
        fr = v & width_mask(dbl ? 52 : 23);
        efmax = dbl ? 64'h7FF : 64'hFF;
        nan = (ef == efmax) && fr != 0;
        inf = (ef == efmax) && fr == 0;
        if (ef == 0) begin
          m = fr;
          e = dbl ? -1074 : -149;
        end else begin
          m = fr | (64'd1 << (dbl ? 52 : 23));
          e = int'(ef) - (dbl ? 1075 : 150);
        end
        if (dt <= T_I64) r = float_to_int(neg, m, e, inf, nan, type_bits(dt));
        else if (dt == st) r = v;
        else if (dt == T_F64) begin
          if (nan) r = {neg, 11'h7FF, 1'b1, 51'd0} | (fr << 29);
          else if (inf) r = {neg, 11'h7FF, 52'd0};
          else r = round_to_float(neg, m, e, 1);
        end else begin
          if (nan) r = {32'd0, neg, 31'h7FC0_0000} | (fr >> 29);
          else if (inf) r = {32'd0, neg, 31'h7F80_0000};
          else r = round_to_float(neg, m, e, 0);
        end
      end
      return r & width_mask(type_bits(dt));
    endfunction

    function void note_issue(op_e op, logic [2:0] st, logic [2:0] dt, logic [63:0] raw);
      owed_q.push_back(convert(op, st, dt, raw));
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        $display("%0t: result_value expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  conversion_board board;
  int unsigned cycle_count;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Note accepted transactions and check results on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy) board.note_issue(op_e'(opcode_i), src_type_i, dst_type_i,
                                             source_value_i);
      if (result_valid_o) board.check_result(result_value_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("numeric_format_converter_unit_test: errors");
      $finish;
    end
  end

  // Hold the transaction on the bus until an edge with busy low takes it.
  task automatic send(op_e op, logic [2:0] st, logic [2:0] dt, logic [63:0] val);
    bit was_busy;
    start_i        <= 1'b1;
    opcode_i       <= op;
    src_type_i     <= st;
    dst_type_i     <= dt;
    source_value_i <= val;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
  endtask

  task automatic pause(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [2:0] pick_type(bit allow_unused);
    if (allow_unused && $urandom_range(0, 19) == 0) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(T_I8, T_F64));
  endfunction

  // Bias operands toward exponent edges, ties and integer limits.
  function automatic logic [63:0] pick_value(logic [2:0] st);
    logic [63:0] v;
    int unsigned ex;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v;
      1: begin
        case ($urandom_range(0, 4))
          0: ex = 0;
          1: ex = 1;
          2: ex = 2046;
          3: ex = 2047;
          default: ex = $urandom_range(800, 1250);
        endcase
        v[62:52] = 11'(ex);
        if ($urandom_range(0, 2) == 0) v[28:0] = {1'b1, 28'd0};
      end
      2: begin
        case ($urandom_range(0, 4))
          0: ex = 0;
          1: ex = 1;
          2: ex = 254;
          3: ex = 255;
          default: ex = $urandom_range(100, 195);
        endcase
        v[30:23] = 8'(ex);
      end
      3: v = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63)) : -64'($urandom_range(0, 3));
      4: v = v >> $urandom_range(0, 63);
      default: v = v ^ (64'h1 << $urandom_range(0, 63));
    endcase
    return v;
  endfunction

  initial begin
    logic [2:0] st;
    board = new();
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    opcode_i <= OP_CONVERT;
    src_type_i <= T_I8;
    dst_type_i <= T_I8;
    source_value_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: limits, specials, ties, byte reverse and unused codes.
    send(OP_CONVERT, T_I64, T_F32, 64'h8000_0000_0000_0000);
    send(OP_CONVERT, T_I64, T_F64, 64'h7FFF_FFFF_FFFF_FFFF);
    send(OP_CONVERT, T_I32, T_F32, 64'h0000_0000_0100_0003);
    send(OP_CONVERT, T_I8, T_I64, 64'hFFFF_FFFF_FFFF_FF80);
    send(OP_CONVERT, T_I64, T_I16, 64'h1234_5678_9ABC_DEF0);
    send(OP_CONVERT, T_F64, T_I32, 64'h7FF8_0000_0000_0001);
    send(OP_CONVERT, T_F64, T_I64, 64'hFFF0_0000_0000_0000);
    send(OP_CONVERT, T_F32, T_I8, 64'h0000_0000_7F80_0000);
    send(OP_CONVERT, T_F32, T_I16, 64'h0000_0000_C780_0000);
    send(OP_CONVERT, T_F64, T_F32, 64'h7FF4_0000_2000_0000);
    send(OP_CONVERT, T_F32, T_F64, 64'h0000_0000_FFA0_0001);
    send(OP_CONVERT, T_F64, T_F32, 64'h47F0_0000_0000_0000);
    send(OP_CONVERT, T_F64, T_F32, 64'h8000_0000_0000_0001);
    send(OP_CONVERT, T_F64, T_F32, 64'h3690_0000_0000_0000);
    send(OP_CONVERT, T_F32, T_F64, 64'h0000_0000_0000_0001);
    send(OP_CONVERT, T_F64, T_F64, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_CONVERT, T_F32, T_F32, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_CONVERT, T_F64, T_I64, 64'h3FE0_0000_0000_0000);
    send(OP_BSWAP, T_I8, T_I8, 64'hFFFF_FFFF_FFFF_FFA5);
    send(OP_BSWAP, T_I16, T_I8, 64'h0123_4567_89AB_CDEF);
    send(OP_BSWAP, T_F32, T_I8, 64'h0123_4567_89AB_CDEF);
    send(OP_BSWAP, T_F64, T_I8, 64'h0123_4567_89AB_CDEF);
    send(OP_CONVERT, 3'd6, T_I8, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_CONVERT, T_I32, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_BSWAP, 3'd7, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random bursts; after two bursts in three the stimulus drops into a gap.
    for (int n = 0; n < RandomItems; ) begin
      int unsigned burst;
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < RandomItems; k++, n++) begin
        st = pick_type(1);
        send(($urandom_range(0, 5) == 0) ? OP_BSWAP : OP_CONVERT, st, pick_type(1),
             pick_value(st));
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
    start_i <= 1'b0;

    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("numeric_format_converter_unit_test: clean");
    end else begin
      $display("numeric_format_converter_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/nfc_pkg.sv
src/nfc_unpack.sv
src/nfc_normalize.sv
src/nfc_align.sv
src/nfc_pack.sv
src/numeric_format_converter_unit.sv
src/nfc_checker.sv
sim/numeric_format_converter_unit_test.sv
